FILE: design/tbb_pkg.sv
// ----------------------------------------------------------------------------
// tbb_pkg
// Shared types, constants and helpers for the Bernstein basis evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package tbb_pkg;

    localparam int NB = 4;

    typedef logic signed [31:0] val_t;
    typedef logic signed [33:0] der_t;
    typedef logic signed [15:0] coord_t;
    typedef logic signed [23:0] res_t;

    localparam val_t Q30_ONE = 32'sd1073741824;

    typedef enum logic [0:0] {
        REG_ORDER = 1'b0,
        REG_DIMS  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } axis_en_t;

    typedef struct packed {
        val_t       vr;
        der_t       dr;
        val_t       vs;
        der_t       ds;
        val_t       vt;
        der_t       dt;
        logic [5:0] index;
        logic       last;
    } comb_in_t;

    typedef struct packed {
        res_t       value;
        res_t       gr;
        res_t       gs;
        res_t       gt;
        logic [5:0] index;
        logic       last;
    } comb_out_t;

    function automatic res_t sat24(input logic signed [25:0] v);
        res_t r;
        if (v > 26'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -26'sd8388608)
            r = 24'sh800000;
        else
            r = v[23:0];
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/tbb_point_if.sv
// ----------------------------------------------------------------------------
// tbb_point_if
// Valid/ready channel carrying one reference point.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbb_point_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r_coord;
    logic signed [15:0] s_coord;
    logic signed [15:0] t_coord;

    modport source (output valid, output r_coord, output s_coord, output t_coord,
                    input ready);
    modport sink (input valid, input r_coord, input s_coord, input t_coord,
                  output ready);
endinterface

`default_nettype wire

FILE: design/tbb_basis_if.sv
// ----------------------------------------------------------------------------
// tbb_basis_if
// Valid/ready channel carrying one basis function item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tbb_basis_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] basis_value;
    logic signed [23:0] grad_r;
    logic signed [23:0] grad_s;
    logic signed [23:0] grad_t;
    logic [5:0]         basis_index;
    logic               last_of_run;

    modport source (output valid, output basis_value, output grad_r, output grad_s,
                    output grad_t, output basis_index, output last_of_run,
                    input ready);
    modport sink (input valid, input basis_value, input grad_r, input grad_s,
                  input grad_t, input basis_index, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

FILE: design/tensor_bezier_basis_eval_core.sv
// ----------------------------------------------------------------------------
// tensor_bezier_basis_eval_core
// Tensor-product Bernstein basis and gradient evaluator.
// A run's first item is valid after the axis stages, the table bank and the
// product pipeline. Throughput: one item per cycle unless basis.ready stalls;
// a point yields (p+1)^d items, stepped by the index sequencer.
// Reset clears all valid bits; order resets to 1 and dims to 3.
// ----------------------------------------------------------------------------
`default_nettype none

module tensor_bezier_basis_eval_core
    import tbb_pkg::*;
#(
    parameter int MAX_ORDER = 3
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [0:0] cfg_index,
    input  wire logic [1:0] cfg_wdata,
    tbb_point_if.sink       point,
    tbb_basis_if.source     basis
);

    logic [1:0] order_reg, dims_reg;
    logic [1:0] p_eff, d_eff;
    logic [2:0] pp1;

    logic a1_v_reg, a2_v_reg, a3_v_reg;
    logic a1_en, a2_en, a3_en, load;
    axis_en_t aen;

    val_t vr_w [NB], vs_w [NB], vt_w [NB];
    der_t dr_w [NB], ds_w [NB], dt_w [NB];
    val_t vr_reg [NB], vs_reg [NB], vt_reg [NB];
    der_t dr_reg [NB], ds_reg [NB], dt_reg [NB];

    logic       busy_reg;
    logic [1:0] i_reg, j_reg, k_reg;
    logic [1:0] nj_m1, nk_m1;
    logic       i_end, j_end, k_end, seq_last;
    logic       en;
    logic       v1_reg, v2_reg, v3_reg, ov_reg;
    comb_in_t   cin;
    comb_out_t  cout;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 2'd1;
            dims_reg  <= 2'd3;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_ORDER: order_reg <= cfg_wdata;
                REG_DIMS:  dims_reg  <= cfg_wdata;
            endcase
        end
    end

    always_comb
    begin
        p_eff = (32'(order_reg) > MAX_ORDER) ? 2'(MAX_ORDER) : order_reg;
        d_eff = (dims_reg == 2'd0) ? 2'd1 : dims_reg;
        pp1   = 3'(p_eff) + 3'd1;
        nj_m1 = (d_eff >= 2'd2) ? p_eff : 2'd0;
        nk_m1 = (d_eff >= 2'd3) ? p_eff : 2'd0;
        i_end = (i_reg == p_eff);
        j_end = (j_reg == nj_m1);
        k_end = (k_reg == nk_m1);
        seq_last = i_end && j_end && k_end;
    end

    // output pipeline moves as a whole
    assign en = !ov_reg || basis.ready;

    assign load  = a3_v_reg && (!busy_reg || (en && seq_last));
    assign a3_en = !a3_v_reg || load;
    assign a2_en = !a2_v_reg || a3_en;
    assign a1_en = !a1_v_reg || a2_en;
    assign point.ready = a1_en;
    assign aen = '{en1: a1_en, en2: a2_en, en3: a3_en};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_v_reg <= 1'b0;
            a2_v_reg <= 1'b0;
            a3_v_reg <= 1'b0;
        end
        else
        begin
            if (a1_en)
                a1_v_reg <= point.valid;
            if (a2_en)
                a2_v_reg <= a1_v_reg;
            if (a3_en)
                a3_v_reg <= a2_v_reg;
        end
    end

    tbb_axis u_axis_r (.clk(clk), .en(aen), .coord(point.r_coord), .order(p_eff),
                       .vals(vr_w), .ders(dr_w));
    tbb_axis u_axis_s (.clk(clk), .en(aen), .coord(point.s_coord), .order(p_eff),
                       .vals(vs_w), .ders(ds_w));
    tbb_axis u_axis_t (.clk(clk), .en(aen), .coord(point.t_coord), .order(p_eff),
                       .vals(vt_w), .ders(dt_w));

    // table bank held for the run
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vr_reg <= vr_w;
            dr_reg <= dr_w;
            vs_reg <= vs_w;
            ds_reg <= ds_w;
            vt_reg <= vt_w;
            dt_reg <= dt_w;
            if (d_eff < 2'd2)
            begin
                vs_reg[0] <= Q30_ONE;
                ds_reg[0] <= '0;
            end
            if (d_eff < 2'd3)
            begin
                vt_reg[0] <= Q30_ONE;
                dt_reg[0] <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= 2'd0;
            j_reg    <= 2'd0;
            k_reg    <= 2'd0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            i_reg    <= 2'd0;
            j_reg    <= 2'd0;
            k_reg    <= 2'd0;
        end
        else if (busy_reg && en)
        begin
            if (seq_last)
                busy_reg <= 1'b0;
            else if (!i_end)
                i_reg <= i_reg + 2'd1;
            else
            begin
                i_reg <= 2'd0;
                if (!j_end)
                    j_reg <= j_reg + 2'd1;
                else
                begin
                    j_reg <= 2'd0;
                    k_reg <= k_reg + 2'd1;
                end
            end
        end
    end

    always_comb
    begin
        cin.vr    = vr_reg[i_reg];
        cin.dr    = dr_reg[i_reg];
        cin.vs    = vs_reg[j_reg];
        cin.ds    = ds_reg[j_reg];
        cin.vt    = vt_reg[k_reg];
        cin.dt    = dt_reg[k_reg];
        cin.index = 6'(i_reg) + 6'(pp1) * 6'(j_reg) + 6'(pp1) * 6'(pp1) * 6'(k_reg);
        cin.last  = seq_last;
    end

    tbb_comb u_comb (.clk(clk), .en(en), .din(cin), .dout(cout));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= busy_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            ov_reg <= v3_reg;
        end
    end

    assign basis.valid       = ov_reg;
    assign basis.basis_value = cout.value;
    assign basis.grad_r      = cout.gr;
    assign basis.grad_s      = cout.gs;
    assign basis.grad_t      = cout.gt;
    assign basis.basis_index = cout.index;
    assign basis.last_of_run = cout.last;

endmodule

`default_nettype wire

FILE: design/tbb_axis.sv
// ----------------------------------------------------------------------------
// tbb_axis
// Three-stage 1D Bernstein value and doubled-derivative table for one axis.
// ----------------------------------------------------------------------------
`default_nettype none

module tbb_axis
    import tbb_pkg::*;
(
    input  wire logic     clk,
    input  wire axis_en_t en,
    input  wire coord_t   coord,
    input  wire logic [1:0] order,
    output val_t          vals [NB],
    output der_t          ders [NB]
);

    logic signed [17:0] c_w;
    logic signed [17:0] lo_w;
    logic signed [17:0] hi_w;

    logic [15:0] lo1_reg, hi1_reg;
    logic [15:0] lo2_reg, hi2_reg;
    logic [30:0] lolo_reg, hihi_reg, lohi_reg;

    logic [46:0] lo3_w, lo2hi_w, lohi2_w, hi3_w;
    logic [48:0] t0_w, t1_w, t2_w, t3_w;
    logic signed [33:0] sq_lo, sq_hi, sq_x, l16, h16;
    val_t vals_next [NB];
    der_t ders_next [NB];
    val_t vals_reg [NB];
    der_t ders_reg [NB];

    always_comb
    begin
        c_w = 18'(coord);
        if (c_w < -18'sd16384)
            c_w = -18'sd16384;
        else if (c_w > 18'sd16384)
            c_w = 18'sd16384;
        lo_w = 18'sd16384 - c_w;
        hi_w = 18'sd16384 + c_w;
    end

    always_ff @(posedge clk)
    begin
        if (en.en1)
        begin
            lo1_reg <= lo_w[15:0];
            hi1_reg <= hi_w[15:0];
        end
        if (en.en2)
        begin
            lo2_reg  <= lo1_reg;
            hi2_reg  <= hi1_reg;
            lolo_reg <= 31'(32'(lo1_reg) * 32'(lo1_reg));
            hihi_reg <= 31'(32'(hi1_reg) * 32'(hi1_reg));
            lohi_reg <= 31'(32'(lo1_reg) * 32'(hi1_reg));
        end
        if (en.en3)
        begin
            vals_reg <= vals_next;
            ders_reg <= ders_next;
        end
    end

    always_comb
    begin
        lo3_w   = 47'(lolo_reg) * 47'(lo2_reg);
        lo2hi_w = 47'(lolo_reg) * 47'(hi2_reg);
        lohi2_w = 47'(lohi_reg) * 47'(hi2_reg);
        hi3_w   = 47'(hihi_reg) * 47'(hi2_reg);
        t0_w = 49'(lo3_w) + 49'd16384;
        t1_w = 49'(lo2hi_w) * 49'd3 + 49'd16384;
        t2_w = 49'(lohi2_w) * 49'd3 + 49'd16384;
        t3_w = 49'(hi3_w) + 49'd16384;
        sq_lo = $signed({3'b000, lolo_reg});
        sq_hi = $signed({3'b000, hihi_reg});
        sq_x  = $signed({3'b000, lohi_reg});
        l16   = $signed({2'b00, lo2_reg, 16'd0});
        h16   = $signed({2'b00, hi2_reg, 16'd0});
        for (int n = 0; n < NB; n++)
        begin
            vals_next[n] = '0;
            ders_next[n] = '0;
        end
        unique case (order)
            2'd0:
            begin
                vals_next[0] = Q30_ONE;
            end
            2'd1:
            begin
                vals_next[0] = $signed({1'b0, lo2_reg, 15'd0});
                vals_next[1] = $signed({1'b0, hi2_reg, 15'd0});
                ders_next[0] = -34'(Q30_ONE);
                ders_next[1] = 34'(Q30_ONE);
            end
            2'd2:
            begin
                vals_next[0] = $signed({1'b0, lolo_reg});
                vals_next[1] = $signed({lohi_reg, 1'b0});
                vals_next[2] = $signed({1'b0, hihi_reg});
                ders_next[0] = -l16;
                ders_next[1] = l16 - h16;
                ders_next[2] = h16;
            end
            default:
            begin
                vals_next[0] = $signed({1'b0, t0_w[45:15]});
                vals_next[1] = $signed({1'b0, t1_w[45:15]});
                vals_next[2] = $signed({1'b0, t2_w[45:15]});
                vals_next[3] = $signed({1'b0, t3_w[45:15]});
                ders_next[0] = -(sq_lo * 34'sd3);
                ders_next[1] = (sq_lo - (sq_x <<< 1)) * 34'sd3;
                ders_next[2] = ((sq_x <<< 1) - sq_hi) * 34'sd3;
                ders_next[3] = sq_hi * 34'sd3;
            end
        endcase
    end

    assign vals = vals_reg;
    assign ders = ders_reg;

endmodule

`default_nettype wire

FILE: design/tbb_comb.sv
// ----------------------------------------------------------------------------
// tbb_comb
// Four-stage product pipeline: two multiplies, each followed by rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module tbb_comb
    import tbb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     en,
    input  wire comb_in_t din,
    output comb_out_t     dout
);

    logic signed [65:0] pa_reg, pb_reg, pc_reg;
    val_t       vt1_reg, vt2_reg;
    der_t       dt1_reg, dt2_reg;
    logic [5:0] idx1_reg, idx2_reg, idx3_reg;
    logic       last1_reg, last2_reg, last3_reg;

    logic signed [65:0] ra_w, rb_w, rc_w;
    logic signed [35:0] ma_reg, mb_reg, mc_reg;

    logic signed [69:0] qv_reg, qr_reg, qs_reg, qt_reg;
    logic signed [69:0] sv_w, sr_w, ss_w, st_w;
    comb_out_t          out_reg;

    always_comb
    begin
        ra_w = (pa_reg + 66'sd536870912) >>> 30;
        rb_w = (pb_reg + 66'sd536870912) >>> 30;
        rc_w = (pc_reg + 66'sd536870912) >>> 30;
        sv_w = (qv_reg + (70'sd1 <<< 43)) >>> 44;
        sr_w = (qr_reg + (70'sd1 <<< 44)) >>> 45;
        ss_w = (qs_reg + (70'sd1 <<< 44)) >>> 45;
        st_w = (qt_reg + (70'sd1 <<< 44)) >>> 45;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg    <= 66'(din.vr) * 66'(din.vs);
            pb_reg    <= 66'(din.dr) * 66'(din.vs);
            pc_reg    <= 66'(din.vr) * 66'(din.ds);
            vt1_reg   <= din.vt;
            dt1_reg   <= din.dt;
            idx1_reg  <= din.index;
            last1_reg <= din.last;

            ma_reg    <= ra_w[35:0];
            mb_reg    <= rb_w[35:0];
            mc_reg    <= rc_w[35:0];
            vt2_reg   <= vt1_reg;
            dt2_reg   <= dt1_reg;
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;

            qv_reg    <= 70'(ma_reg) * 70'(vt2_reg);
            qr_reg    <= 70'(mb_reg) * 70'(vt2_reg);
            qs_reg    <= 70'(mc_reg) * 70'(vt2_reg);
            qt_reg    <= 70'(ma_reg) * 70'(dt2_reg);
            idx3_reg  <= idx2_reg;
            last3_reg <= last2_reg;

            out_reg.value <= sat24(sv_w[25:0]);
            out_reg.gr    <= sat24(sr_w[25:0]);
            out_reg.gs    <= sat24(ss_w[25:0]);
            out_reg.gt    <= sat24(st_w[25:0]);
            out_reg.index <= idx3_reg;
            out_reg.last  <= last3_reg;
        end
    end

    assign dout = out_reg;

endmodule

`default_nettype wire
